[rtl/core/smm_pkg.sv]
// ----------------------------------------------------------------------------
// smm_pkg
// Shared widths and types for the square matrix multiply block.
// ----------------------------------------------------------------------------
package smm_pkg;

	localparam int IDX_W  = 3;
	localparam int VAL_W  = 16;
	localparam int MUL_W  = 2 * VAL_W;
	localparam int PROD_W = 35;
	localparam int SIZE_W = 4;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);

	// one multiply-accumulate step, travels beside the store read
	typedef struct packed {
		logic             vld;
		logic             first;
		logic             last;
		logic             fin;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} step_t;

endpackage

[rtl/core/smm_store.sv]
// ----------------------------------------------------------------------------
// smm_store
// Synchronous memory, one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module smm_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [AW-1:0]                waddr,
	input  logic [smm_pkg::VAL_W-1:0]    wdata,
	input  logic [AW-1:0]                raddr,
	output logic [smm_pkg::VAL_W-1:0]    rdata
);

	logic [smm_pkg::VAL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/smm_ctrl.sv]
// ----------------------------------------------------------------------------
// smm_ctrl
// Sequencer: walks i, j, k over the effective size, one store read per cycle.
// ----------------------------------------------------------------------------
module smm_ctrl #(
	parameter int MAX_DIM = 8,
	parameter int AW      = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  logic [smm_pkg::SIZE_W-1:0]  size,
	input  logic                        res_vld,
	input  logic                        res_last,
	output logic                        busy,
	output logic [AW-1:0]               left_raddr,
	output logic [AW-1:0]               right_raddr,
	output smm_pkg::step_t              step
);

	localparam int SIZE_CAP = (MAX_DIM < 8) ? MAX_DIM : 8;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t                      state_q;
	logic [smm_pkg::IDX_W-1:0]   i_q, j_q, k_q, nm1_q;
	logic [smm_pkg::SIZE_W-1:0]  n_eff;
	logic                        k_end, j_end, i_end;

	always_comb begin
		if (size == '0) begin
			n_eff = smm_pkg::SIZE_W'(1);
		end else if (size > smm_pkg::SIZE_W'(SIZE_CAP)) begin
			n_eff = smm_pkg::SIZE_W'(SIZE_CAP);
		end else begin
			n_eff = size;
		end
	end

	assign k_end = (k_q == nm1_q);
	assign j_end = (j_q == nm1_q);
	assign i_end = (i_q == nm1_q);

	assign busy        = (state_q != ST_IDLE);
	assign left_raddr  = AW'(i_q) * AW'(MAX_DIM) + AW'(k_q);
	assign right_raddr = AW'(k_q) * AW'(MAX_DIM) + AW'(j_q);

	always_comb begin
		step.vld   = (state_q == ST_RUN);
		step.first = (k_q == '0);
		step.last  = k_end;
		step.fin   = k_end && j_end && i_end;
		step.row   = i_q;
		step.col   = j_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			nm1_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (go) begin
						nm1_q   <= smm_pkg::IDX_W'(n_eff - smm_pkg::SIZE_W'(1));
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (k_end) begin
						k_q <= '0;
						if (j_end) begin
							j_q <= '0;
							if (i_end) begin
								state_q <= ST_DRAIN;
							end else begin
								i_q <= i_q + 1'b1;
							end
						end else begin
							j_q <= j_q + 1'b1;
						end
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (res_vld && res_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/core/smm_mac.sv]
// ----------------------------------------------------------------------------
// smm_mac
// Multiply-accumulate: registered product, exact 35-bit running sum, result
// register.
// ----------------------------------------------------------------------------
module smm_mac (
	input  logic                              clk,
	input  logic                              arst_n,
	input  smm_pkg::step_t                    step,
	input  logic signed [smm_pkg::VAL_W-1:0]  a_s1,
	input  logic signed [smm_pkg::VAL_W-1:0]  b_s1,
	output logic                              res_vld,
	output logic [smm_pkg::IDX_W-1:0]         res_row,
	output logic [smm_pkg::IDX_W-1:0]         res_col,
	output logic signed [smm_pkg::PROD_W-1:0] res_sum,
	output logic                              res_last
);

	smm_pkg::step_t                      step_s1, step_s2;
	logic signed [smm_pkg::MUL_W-1:0]    mul_s2;
	logic signed [smm_pkg::PROD_W-1:0]   acc_q, acc_nxt;

	assign acc_nxt = (step_s2.first ? '0 : acc_q)
		+ smm_pkg::PROD_W'(mul_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_s1  <= '0;
			step_s2  <= '0;
			res_vld  <= 1'b0;
			res_last <= 1'b0;
		end else begin
			step_s1  <= step;
			step_s2  <= step_s1;
			res_vld  <= step_s2.vld && step_s2.last;
			res_last <= step_s2.vld && step_s2.fin;
		end
	end

	always_ff @(posedge clk) begin
		mul_s2 <= a_s1 * b_s1;
		if (step_s2.vld) begin
			acc_q <= acc_nxt;
			if (step_s2.last) begin
				res_row <= step_s2.row;
				res_col <= step_s2.col;
				res_sum <= acc_nxt;
			end
		end
	end

endmodule

[rtl/core/square_matrix_multiply.sv]
// ----------------------------------------------------------------------------
// square_matrix_multiply
// Loads two square Q8.8 matrices element by element, then emits C = A * B.
// ----------------------------------------------------------------------------
// Usage:
//   Load items: kind/row/col/value are taken at an edge with start high and
//   busy low; one item per cycle. kind 0 writes A, kind 1 writes B. An index
//   not below MAX_DIM is dropped. final_load starts the multiply after the
//   element is stored; busy then stays high until the run ends.
//   Results: n*n items, row-major, each shown for one cycle with result_valid;
//   last_result marks the final one. The receiver cannot stall.
//   Flow: one store read pair per cycle from each memory; each product
//   element sums n products through registered read data, product and sum.
//   Config: cfg_we writes matrix_size; the user must do so while idle, the
//   block does not enforce it. 0 acts as 1, values above min(MAX_DIM,8) are
//   clamped. Reset sets matrix_size to 8; stores are not cleared, and
//   unwritten entries read as garbage.
// ----------------------------------------------------------------------------
module square_matrix_multiply #(
	parameter int MAX_DIM = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              kind,
	input  logic [smm_pkg::IDX_W-1:0]         row,
	input  logic [smm_pkg::IDX_W-1:0]         col,
	input  logic signed [smm_pkg::VAL_W-1:0]  value,
	input  logic                              final_load,
	input  logic                              cfg_we,
	input  logic [smm_pkg::SIZE_W-1:0]        cfg_wdata,
	output logic                              result_valid,
	output logic [smm_pkg::IDX_W-1:0]         out_row,
	output logic [smm_pkg::IDX_W-1:0]         out_col,
	output logic signed [smm_pkg::PROD_W-1:0] product,
	output logic                              last_result
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);

	logic [smm_pkg::SIZE_W-1:0] size_q;
	logic                       accept, in_range;
	logic [AW-1:0]              waddr, left_raddr, right_raddr;
	logic [smm_pkg::VAL_W-1:0]  left_rdata, right_rdata;
	smm_pkg::step_t             step;

	assign accept   = start && !busy;
	assign in_range = (32'(row) < MAX_DIM) && (32'(col) < MAX_DIM);
	assign waddr    = AW'(row) * AW'(MAX_DIM) + AW'(col);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= smm_pkg::SIZE_RESET;
		end else if (cfg_we) begin
			size_q <= cfg_wdata;
		end
	end

	smm_store #(.DEPTH(DEPTH), .AW(AW)) u_left (
		.clk   (clk),
		.we    (accept && in_range && !kind),
		.waddr (waddr),
		.wdata (value),
		.raddr (left_raddr),
		.rdata (left_rdata)
	);

	smm_store #(.DEPTH(DEPTH), .AW(AW)) u_right (
		.clk   (clk),
		.we    (accept && in_range && kind),
		.waddr (waddr),
		.wdata (value),
		.raddr (right_raddr),
		.rdata (right_rdata)
	);

	smm_ctrl #(.MAX_DIM(MAX_DIM), .AW(AW)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (accept && final_load),
		.size        (size_q),
		.res_vld     (result_valid),
		.res_last    (last_result),
		.busy        (busy),
		.left_raddr  (left_raddr),
		.right_raddr (right_raddr),
		.step        (step)
	);

	smm_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.a_s1     (left_rdata),
		.b_s1     (right_rdata),
		.res_vld  (result_valid),
		.res_row  (out_row),
		.res_col  (out_col),
		.res_sum  (product),
		.res_last (last_result)
	);

	a_result_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result outside a run");

	a_last_is_result: assert property (@(posedge clk) disable iff (!arst_n)
		last_result |-> result_valid)
		else $error("last flag without result");

	a_run_from_final: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && final_load))
		else $error("run started without final load");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_result) |=> !busy)
		else $error("busy held after last result");

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for square_matrix_multiply. Elements of A and B are
// loaded through the start/busy handshake; each final load is predicted by a
// local exact Q16.16 product model and every strobed result is checked in
// order against it. Covers size clamping, Q8.8 extremes, loads without a
// multiply, and random gaps on the load side.
// ----------------------------------------------------------------------------

typedef struct {
	logic [smm_pkg::IDX_W-1:0]         row;
	logic [smm_pkg::IDX_W-1:0]         col;
	logic signed [smm_pkg::PROD_W-1:0] sum;
	logic                              last;
} product_t;

class product_board;
	localparam int DIM = 8;

	logic signed [smm_pkg::VAL_W-1:0] left_m [DIM][DIM];
	logic signed [smm_pkg::VAL_W-1:0] right_m [DIM][DIM];
	logic [smm_pkg::SIZE_W-1:0]       size_reg;
	product_t                         pending_products[$];
	int                               errors;

	function new();
		size_reg = smm_pkg::SIZE_RESET;
		errors   = 0;
	endfunction

	function void set_size(logic [smm_pkg::SIZE_W-1:0] v);
		size_reg = v;
	endfunction

	function int dim();
		int n;
		n = int'(size_reg);
		if (n < 1) n = 1;
		if (n > DIM) n = DIM;
		return n;
	endfunction

	// store the element, and on a final load queue all of C = A * B
	function void load_element(logic k, logic [smm_pkg::IDX_W-1:0] r,
			logic [smm_pkg::IDX_W-1:0] c, logic signed [smm_pkg::VAL_W-1:0] v,
			logic fin);
		int       n;
		longint   acc;
		product_t pr;
		if (k == 1'b0) left_m[r][c] = v;
		else right_m[r][c] = v;
		if (!fin) return;
		n = dim();
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j < n; j++) begin
				acc = 0;
				for (int m = 0; m < n; m++)
					acc += longint'(left_m[i][m]) * longint'(right_m[m][j]);
				pr.row  = smm_pkg::IDX_W'(i);
				pr.col  = smm_pkg::IDX_W'(j);
				pr.sum  = acc[smm_pkg::PROD_W-1:0];
				pr.last = (i == n - 1) && (j == n - 1);
				pending_products.push_back(pr);
			end
		end
	endfunction

	function void check_product(logic [smm_pkg::IDX_W-1:0] r,
			logic [smm_pkg::IDX_W-1:0] c, logic signed [smm_pkg::PROD_W-1:0] p,
			logic l);
		product_t want;
		if (pending_products.size() == 0) begin
			$error("unexpected product row %0d col %0d value %0d", r, c, p);
			errors++;
			return;
		end
		want = pending_products.pop_front();
		if (r !== want.row) begin
			$error("out_row: expected %0d, got %0d", want.row, r);
			errors++;
		end
		if (c !== want.col) begin
			$error("out_col: expected %0d, got %0d", want.col, c);
			errors++;
		end
		if (p !== want.sum) begin
			$error("product: expected %0d, got %0d", want.sum, p);
			errors++;
		end
		if (l !== want.last) begin
			$error("last_result: expected %0b, got %0b", want.last, l);
			errors++;
		end
	endfunction
endclass

module tb;

	localparam int ITEMS_TARGET = 320;
	localparam int STALL_LIMIT  = 2000;

	typedef enum {FILL_RANDOM, FILL_CORNER, FILL_MIN} fill_mode_t;

	logic                                     clk;
	logic                                     arst_n;
	logic                                     start;
	logic                                     busy;
	logic                                     kind;
	logic [smm_pkg::IDX_W-1:0]                row;
	logic [smm_pkg::IDX_W-1:0]                col;
	logic signed [smm_pkg::VAL_W-1:0]         value;
	logic                                     final_load;
	logic                                     cfg_we;
	logic [smm_pkg::SIZE_W-1:0]               cfg_wdata;
	logic                                     result_valid;
	logic [smm_pkg::IDX_W-1:0]                out_row;
	logic [smm_pkg::IDX_W-1:0]                out_col;
	logic signed [smm_pkg::PROD_W-1:0]        product;
	logic                                     last_result;

	product_board board;
	int           accepted;
	int           stall_cycles;
	bit           a_seen [8][8];
	bit           b_seen [8][8];

	square_matrix_multiply #(.MAX_DIM(8)) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.row          (row),
		.col          (col),
		.value        (value),
		.final_load   (final_load),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result_valid (result_valid),
		.out_row      (out_row),
		.out_col      (out_col),
		.product      (product),
		.last_result  (last_result)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && result_valid)
			board.check_product(out_row, out_col, product, last_result);
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles == STALL_LIMIT) begin
			$display("[square_matrix_multiply] ERROR");
			$finish;
		end
	end

	function automatic logic [smm_pkg::VAL_W-1:0] pick_value(fill_mode_t mode);
		logic [smm_pkg::VAL_W-1:0] corners [5];
		corners = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
		case (mode)
			FILL_MIN:    return 16'h8000;
			FILL_CORNER: return corners[$urandom_range(4)];
			default:     return smm_pkg::VAL_W'($urandom);
		endcase
	endfunction

	task automatic send_item(input logic el_kind,
			input logic [smm_pkg::IDX_W-1:0] el_row,
			input logic [smm_pkg::IDX_W-1:0] el_col,
			input logic [smm_pkg::VAL_W-1:0] el_val,
			input logic el_fin);
		bit steady;
		steady = (accepted >= 150) && (accepted < 230);
		while (!steady && $urandom_range(99) < 29) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start      <= 1'b1;
		kind       <= el_kind;
		row        <= el_row;
		col        <= el_col;
		value      <= el_val;
		final_load <= el_fin;
		@(posedge clk);
		while (busy) @(posedge clk);
		board.load_element(el_kind, el_row, el_col, el_val, el_fin);
		if (el_kind == 1'b0) a_seen[el_row][el_col] = 1'b1;
		else b_seen[el_row][el_col] = 1'b1;
		accepted++;
	endtask

	// hold off loads until every product is out and the block is idle
	task automatic drain();
		start <= 1'b0;
		while (board.pending_products.size() != 0) @(posedge clk);
		while (busy) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_size(input logic [smm_pkg::SIZE_W-1:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_size(v);
	endtask

	// random loads, then fill whatever of the n x n area was never written; FILL_MIN loads all of it with 16'h8000 instead
	task automatic run_multiply(input fill_mode_t mode, input bit do_final);
		int                        n;
		logic [smm_pkg::IDX_W-1:0] r;
		logic [smm_pkg::IDX_W-1:0] c;
		n = board.dim();
		if (mode == FILL_MIN) begin
			for (int i = 0; i < n; i++)
				for (int j = 0; j < n; j++) begin
					send_item(1'b0, smm_pkg::IDX_W'(i), smm_pkg::IDX_W'(j), 16'h8000, 1'b0);
					send_item(1'b1, smm_pkg::IDX_W'(i), smm_pkg::IDX_W'(j), 16'h8000, 1'b0);
				end
		end else begin
			repeat ($urandom_range(0, 10)) begin
				if ($urandom_range(3) != 0) begin
					r = smm_pkg::IDX_W'($urandom_range(n - 1));
					c = smm_pkg::IDX_W'($urandom_range(n - 1));
				end else begin
					r = smm_pkg::IDX_W'($urandom);
					c = smm_pkg::IDX_W'($urandom);
				end
				send_item(1'($urandom), r, c, pick_value(mode), 1'b0);
			end
			for (int i = 0; i < n; i++)
				for (int j = 0; j < n; j++) begin
					if (!a_seen[i][j])
						send_item(1'b0, smm_pkg::IDX_W'(i), smm_pkg::IDX_W'(j),
							pick_value(mode), 1'b0);
					if (!b_seen[i][j])
						send_item(1'b1, smm_pkg::IDX_W'(i), smm_pkg::IDX_W'(j),
							pick_value(mode), 1'b0);
				end
		end
		if (do_final) begin
			if (mode == FILL_MIN)
				send_item(1'($urandom), smm_pkg::IDX_W'(n - 1), smm_pkg::IDX_W'(n - 1),
					16'h8000, 1'b1);
			else
				send_item(1'($urandom), smm_pkg::IDX_W'($urandom),
					smm_pkg::IDX_W'($urandom), pick_value(mode), 1'b1);
		end
	endtask

	initial begin
		logic [smm_pkg::SIZE_W-1:0] size_plan [5];
		fill_mode_t                 mode;
		int                         run_idx;

		board        = new();
		accepted     = 0;
		stall_cycles = 0;
		size_plan    = '{4'd15, 4'd8, 4'd0, 4'd1, 4'd9};
		arst_n       = 1'b0;
		start        = 1'b0;
		kind         = 1'b0;
		row          = '0;
		col          = '0;
		value        = '0;
		final_load   = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: size 1 and 0, Q8.8 extremes, 2x2, final outside the size
		set_size(4'd1);
		send_item(1'b0, 3'd0, 3'd0, 16'h8000, 1'b0);
		send_item(1'b1, 3'd0, 3'd0, 16'h8000, 1'b1);
		send_item(1'b0, 3'd0, 3'd0, 16'h7FFF, 1'b1);
		set_size(4'd0);
		send_item(1'b1, 3'd0, 3'd0, 16'h7FFF, 1'b1);
		set_size(4'd2);
		send_item(1'b0, 3'd0, 3'd0, 16'h7FFF, 1'b0);
		send_item(1'b0, 3'd0, 3'd1, 16'h8000, 1'b0);
		send_item(1'b0, 3'd1, 3'd0, 16'h0001, 1'b0);
		send_item(1'b0, 3'd1, 3'd1, 16'hFFFF, 1'b0);
		send_item(1'b1, 3'd0, 3'd0, 16'h8000, 1'b0);
		send_item(1'b1, 3'd0, 3'd1, 16'h0000, 1'b0);
		send_item(1'b1, 3'd1, 3'd0, 16'h7FFF, 1'b0);
		send_item(1'b1, 3'd1, 3'd1, 16'h8000, 1'b1);
		send_item(1'b0, 3'd7, 3'd7, 16'h1234, 1'b1);
		send_item(1'b1, 3'd7, 3'd0, 16'hFFFF, 1'b1);

		run_idx = 0;
		while (accepted < ITEMS_TARGET) begin
			if (run_idx < 5)
				set_size(size_plan[run_idx]);
			else if ($urandom_range(2) == 0)
				set_size(($urandom_range(2) != 0)
					? smm_pkg::SIZE_W'($urandom_range(1, 4))
					: smm_pkg::SIZE_W'($urandom_range(15)));
			else if ($urandom_range(7) == 0)
				drain();
			if (run_idx == 0 || $urandom_range(19) == 0) mode = FILL_MIN;
			else if ($urandom_range(2) == 0) mode = FILL_CORNER;
			else mode = FILL_RANDOM;
			run_multiply(mode, run_idx < 5 || $urandom_range(5) != 0);
			run_idx++;
		end

		drain();
		repeat (16) @(posedge clk);
		if (board.errors == 0 && board.pending_products.size() == 0)
			$display("[square_matrix_multiply] OK");
		else
			$display("[square_matrix_multiply] ERROR");
		$finish;
	end

endmodule

[files.f]
rtl/core/smm_pkg.sv
rtl/core/smm_store.sv
rtl/core/smm_ctrl.sv
rtl/core/smm_mac.sv
rtl/core/square_matrix_multiply.sv
test/tb.sv
